>>> src/tcw_pkg.sv
// Package for the text console writer: sequencer states and fixed codes.
// Used by text_console_writer and tcw_checker; depends on nothing else.
`default_nettype none

package tcw_pkg;

  // Request codes carried in req_type.
  localparam logic ReqPut  = 1'b0;
  localparam logic ReqRead = 1'b1;

  // Character and attribute codes.
  localparam logic [7:0] NewlineCode = 8'd10;
  localparam logic [7:0] SpaceCode   = 8'h20;
  localparam logic [7:0] NulCode     = 8'h00;
  localparam logic [7:0] AttrReset   = 8'h0F;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_SCROLL,
    ST_DRAIN,
    ST_BOTTOM,
    ST_DONE
  } tcw_state_e;

endpackage

`default_nettype wire

>>> src/text_console_writer.sv
// Text-mode console writer: cursor, screen store and history store with scroll.
// Depends on tcw_pkg for the sequencer states and the character codes.
`default_nettype none

// The console takes one request per input beat and returns exactly one result
// beat. A put request with an ordinary code writes the screen and history
// stores at the cursor, and its result is loaded into the result register in
// the cycle it is accepted, so a run of puts that causes no scroll streams at
// one beat per cycle while out_ready_i is high. A read request passes through
// the registered read of the screen store and the ST_READ state. A put
// that runs past the last row starts a scroll: one shared address sequencer
// walks the history store, reading one row below and writing one row up in
// each cycle, then clears the bottom row, each cell written in turn through the
// single write port of the two stores. After reset the same sequencer sweeps
// both stores once to their blank values, and no input beat is accepted during
// the sweep; configuration beats are accepted at all times. The attribute
// register only affects cells written later, including by a scroll.
module text_console_writer #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // Attribute register write channel.
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [7:0] cfg_text_attr_i,
  // Request channel.
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic       req_type_i,
  input  wire logic [7:0] char_code_i,
  input  wire logic [4:0] read_row_i,
  input  wire logic [6:0] read_column_i,
  // Result channel.
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      cell_char_o,
  output logic [7:0]      cell_attr_o,
  output logic [6:0]      now_column_o,
  output logic [4:0]      now_row_o,
  output logic            did_scroll_o
);

  localparam int Cells = ROWS * COLUMNS;
  localparam int AddrW = $clog2(Cells);
  localparam int ColW  = $clog2(COLUMNS);
  localparam int RowW  = $clog2(ROWS);

  localparam logic [AddrW-1:0] LastAddr = AddrW'(Cells - 1);
  localparam logic [AddrW-1:0] RowStep  = AddrW'(COLUMNS);
  localparam logic [ColW:0]    ColEnd   = (ColW + 1)'(COLUMNS);
  localparam logic [RowW-1:0]  LastRow  = RowW'(ROWS - 1);

  // Storage: each screen cell holds the attribute in its high byte.
  logic [15:0] scr_mem  [Cells];
  logic [7:0]  hist_mem [Cells];
  logic [15:0] scr_rd_q;
  logic [7:0]  hist_rd_q;

  tcw_pkg::tcw_state_e state_q, state_d;

  logic [7:0]       text_attr_q;
  logic [ColW-1:0]  col_q, col_d;
  logic [RowW-1:0]  row_q, row_d;
  logic [AddrW-1:0] base_q, base_d;   // row_q * COLUMNS, kept incrementally
  logic [AddrW-1:0] dst_q, dst_d;     // write address of the sweep
  logic [AddrW-1:0] cnt_q, cnt_d;     // read address of the sweep
  logic             pv_q, pv_d;       // a history read is in flight
  logic             scroll_q, scroll_d;
  logic             oor_q, oor_d;     // pending read was out of range

  logic             out_valid_q;
  logic [7:0]       cell_char_q, cell_attr_q;
  logic [6:0]       now_column_q;
  logic [4:0]       now_row_q;
  logic             did_scroll_q;

  // Memory port controls.
  logic             mem_we;
  logic [AddrW-1:0] mem_wa;
  logic [15:0]      scr_wd;
  logic [7:0]       hist_wd;
  logic             scr_re;
  logic             hist_re;

  // Result load controls.
  logic             out_free;
  logic             out_load;
  logic [7:0]       res_char, res_attr;
  logic [ColW-1:0]  res_col;
  logic [RowW-1:0]  res_row;
  logic             res_scroll;

  // Cursor arithmetic for a put.
  logic [AddrW-1:0] put_addr;
  logic             is_newline;
  logic             wrap;
  logic             last_row;
  logic             need_scroll;
  logic [ColW-1:0]  col_nx;
  logic [ColW:0]    col_inc;

  // Read address for a read request.
  logic             rd_in_range;
  logic [31:0]      rd_addr_w;
  logic [AddrW-1:0] rd_addr;
  logic [7:0]       hist_fix;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_attr_q <= tcw_pkg::AttrReset;
    end else if (cfg_valid_i) begin
      text_attr_q <= cfg_text_attr_i;
    end
  end

  assign out_free   = !out_valid_q || out_ready_i;
  assign is_newline = (char_code_i == tcw_pkg::NewlineCode);
  assign put_addr   = base_q + AddrW'(col_q);
  assign col_inc    = {1'b0, col_q} + {{ColW{1'b0}}, 1'b1};
  assign wrap       = is_newline || (col_inc == ColEnd);
  assign col_nx     = wrap ? '0 : col_inc[ColW-1:0];
  assign last_row   = (row_q == LastRow);
  assign need_scroll = wrap && last_row;

  assign rd_in_range = (32'(read_row_i) < 32'(ROWS)) && (32'(read_column_i) < 32'(COLUMNS));
  assign rd_addr_w   = 32'(read_row_i) * 32'(COLUMNS) + 32'(read_column_i);
  assign rd_addr     = rd_addr_w[AddrW-1:0];

  // During a scroll, history codes that were never written show as spaces.
  assign hist_fix = (hist_rd_q == tcw_pkg::NulCode) ? tcw_pkg::SpaceCode : hist_rd_q;

  always_comb begin
    state_d    = state_q;
    col_d      = col_q;
    row_d      = row_q;
    base_d     = base_q;
    dst_d      = dst_q;
    cnt_d      = cnt_q;
    pv_d       = pv_q;
    scroll_d   = scroll_q;
    oor_d      = oor_q;
    mem_we     = 1'b0;
    mem_wa     = dst_q;
    scr_wd     = {text_attr_q, tcw_pkg::SpaceCode};
    hist_wd    = tcw_pkg::SpaceCode;
    scr_re     = 1'b0;
    hist_re    = 1'b0;
    in_ready_o = 1'b0;
    out_load   = 1'b0;
    res_char   = '0;
    res_attr   = '0;
    res_col    = col_q;
    res_row    = row_q;
    res_scroll = 1'b0;

    unique case (state_q)
      tcw_pkg::ST_CLEAR: begin
        mem_we  = 1'b1;
        scr_wd  = {tcw_pkg::AttrReset, tcw_pkg::SpaceCode};
        hist_wd = tcw_pkg::NulCode;
        if (dst_q == LastAddr) begin
          dst_d   = '0;
          state_d = tcw_pkg::ST_IDLE;
        end else begin
          dst_d = dst_q + 1'b1;
        end
      end

      tcw_pkg::ST_IDLE: begin
        in_ready_o = out_free;
        if (in_valid_i && out_free) begin
          if (req_type_i == tcw_pkg::ReqRead) begin
            oor_d   = !rd_in_range;
            scr_re  = rd_in_range;
            state_d = tcw_pkg::ST_READ;
          end else begin
            if (!is_newline) begin
              mem_we  = 1'b1;
              mem_wa  = put_addr;
              scr_wd  = {text_attr_q, char_code_i};
              hist_wd = char_code_i;
            end
            col_d = col_nx;
            if (wrap && !last_row) begin
              row_d  = row_q + 1'b1;
              base_d = base_q + RowStep;
            end
            if (need_scroll) begin
              // Cursor stays at column 0 of the last row; walk the stores.
              scroll_d = 1'b1;
              cnt_d    = RowStep;
              dst_d    = '0;
              pv_d     = 1'b0;
              state_d  = tcw_pkg::ST_SCROLL;
            end else begin
              out_load = 1'b1;
              res_col  = col_nx;
              res_row  = (wrap) ? row_q + 1'b1 : row_q;
            end
          end
        end
      end

      tcw_pkg::ST_READ: begin
        if (out_free) begin
          out_load = 1'b1;
          res_char = oor_q ? 8'h00 : scr_rd_q[7:0];
          res_attr = oor_q ? 8'h00 : scr_rd_q[15:8];
          state_d  = tcw_pkg::ST_IDLE;
        end
      end

      tcw_pkg::ST_SCROLL: begin
        // Read one row below, write the code read last cycle one row up.
        hist_re = 1'b1;
        pv_d    = 1'b1;
        if (pv_q) begin
          mem_we  = 1'b1;
          scr_wd  = {text_attr_q, hist_fix};
          hist_wd = hist_fix;
          dst_d   = dst_q + 1'b1;
        end
        if (cnt_q == LastAddr) begin
          state_d = tcw_pkg::ST_DRAIN;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end

      tcw_pkg::ST_DRAIN: begin
        mem_we  = 1'b1;
        scr_wd  = {text_attr_q, hist_fix};
        hist_wd = hist_fix;
        dst_d   = dst_q + 1'b1;
        pv_d    = 1'b0;
        state_d = tcw_pkg::ST_BOTTOM;
      end

      tcw_pkg::ST_BOTTOM: begin
        mem_we = 1'b1;
        if (dst_q == LastAddr) begin
          dst_d   = '0;
          state_d = tcw_pkg::ST_DONE;
        end else begin
          dst_d = dst_q + 1'b1;
        end
      end

      tcw_pkg::ST_DONE: begin
        if (out_free) begin
          out_load   = 1'b1;
          res_scroll = scroll_q;
          scroll_d   = 1'b0;
          state_d    = tcw_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = tcw_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tcw_pkg::ST_CLEAR;
      col_q       <= '0;
      row_q       <= '0;
      base_q      <= '0;
      dst_q       <= '0;
      cnt_q       <= '0;
      pv_q        <= 1'b0;
      scroll_q    <= 1'b0;
      oor_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      col_q    <= col_d;
      row_q    <= row_d;
      base_q   <= base_d;
      dst_q    <= dst_d;
      cnt_q    <= cnt_d;
      pv_q     <= pv_d;
      scroll_q <= scroll_d;
      oor_q    <= oor_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload; held while the beat waits.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      cell_char_q  <= res_char;
      cell_attr_q  <= res_attr;
      now_column_q <= 7'(res_col);
      now_row_q    <= 5'(res_row);
      did_scroll_q <= res_scroll;
    end
  end

  // One write port shared by both stores, one registered read port each.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      scr_mem[mem_wa]  <= scr_wd;
      hist_mem[mem_wa] <= hist_wd;
    end
    if (scr_re) begin
      scr_rd_q <= scr_mem[rd_addr];
    end
    if (hist_re) begin
      hist_rd_q <= hist_mem[cnt_q];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign cell_char_o  = cell_char_q;
  assign cell_attr_o  = cell_attr_q;
  assign now_column_o = now_column_q;
  assign now_row_o    = now_row_q;
  assign did_scroll_o = did_scroll_q;

endmodule

`default_nettype wire

>>> src/tcw_checker.sv
// Port-level checks for text_console_writer and the bind that attaches them.
// Depends on tcw_pkg for the request codes.
`default_nettype none

module tcw_checker #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_o,
  input wire logic       req_type_i,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic [7:0] cell_char_o,
  input wire logic [7:0] cell_attr_o,
  input wire logic [6:0] now_column_o,
  input wire logic [4:0] now_row_o,
  input wire logic       did_scroll_o
);

  // A stalled result beat keeps its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(cell_char_o)
      && $stable(cell_attr_o) && $stable(now_column_o) && $stable(now_row_o)
      && $stable(did_scroll_o))
    else $error("result beat changed while stalled");

  // A scroll always leaves the cursor at column 0 of the last row.
  a_scroll_cursor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && did_scroll_o |-> now_column_o == 7'd0 && now_row_o == 5'(ROWS - 1))
    else $error("scroll left cursor in wrong place");

  // The reported cursor column is always on screen.
  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> 32'(now_column_o) < 32'(COLUMNS))
    else $error("cursor column off screen");

  // A new request is taken only while the result slot can accept a beat.
  a_ready_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_o || out_ready_i)
    else $error("request taken with result slot blocked");

  // A read request taken while no result beat is pending never reports a scroll.
  a_read_noscroll: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && req_type_i == tcw_pkg::ReqRead && !out_valid_o
      |=> ##1 !(out_valid_o && did_scroll_o))
    else $error("read request reported a scroll");

endmodule

bind text_console_writer tcw_checker #(
  .COLUMNS(COLUMNS),
  .ROWS   (ROWS)
) u_tcw_checker (.*);

`default_nettype wire
